@@ sv/xe_pkg.sv @@
// xe_pkg: shared types, op codes, error codes and register mapping for the x86 emitter
// no dependencies
package xe_pkg;

  localparam int LABEL_SLOTS_DEF    = 32;
  localparam int CODE_ADDR_BITS_DEF = 16;
  localparam int NUM_LABELS         = 32;
  localparam int MAX_RESULTS        = 32;
  localparam int BUF_BYTES          = 20;
  localparam int LEN_W              = 5;

  localparam logic [5:0] OP_MOVI      = 6'd0;
  localparam logic [5:0] OP_MOVR      = 6'd1;
  localparam logic [5:0] OP_CMOVS     = 6'd2;
  localparam logic [5:0] OP_CMOVNE    = 6'd3;
  localparam logic [5:0] OP_CMOVE     = 6'd4;
  localparam logic [5:0] OP_ADD       = 6'd5;
  localparam logic [5:0] OP_ADDI      = 6'd6;
  localparam logic [5:0] OP_SUBI      = 6'd7;
  localparam logic [5:0] OP_AND       = 6'd8;
  localparam logic [5:0] OP_ANDI      = 6'd9;
  localparam logic [5:0] OP_NOT       = 6'd10;
  localparam logic [5:0] OP_OR        = 6'd11;
  localparam logic [5:0] OP_XOR       = 6'd12;
  localparam logic [5:0] OP_SHR       = 6'd13;
  localparam logic [5:0] OP_SHL       = 6'd14;
  localparam logic [5:0] OP_SUB       = 6'd15;
  localparam logic [5:0] OP_MUL       = 6'd16;
  localparam logic [5:0] OP_DIV       = 6'd17;
  localparam logic [5:0] OP_MOD       = 6'd18;
  localparam logic [5:0] OP_LDR       = 6'd19;
  localparam logic [5:0] OP_LDR_STACK = 6'd20;
  localparam logic [5:0] OP_STR_STACK = 6'd21;
  localparam logic [5:0] OP_LDRB      = 6'd22;
  localparam logic [5:0] OP_LDRS      = 6'd23;
  localparam logic [5:0] OP_LDRW      = 6'd24;
  localparam logic [5:0] OP_STRB      = 6'd25;
  localparam logic [5:0] OP_STRW      = 6'd26;
  localparam logic [5:0] OP_STRS      = 6'd27;
  localparam logic [5:0] OP_CALL      = 6'd28;
  localparam logic [5:0] OP_CALL2     = 6'd29;
  localparam logic [5:0] OP_CALL3     = 6'd30;
  localparam logic [5:0] OP_CALLR     = 6'd31;
  localparam logic [5:0] OP_CMPI      = 6'd32;
  localparam logic [5:0] OP_CMPR      = 6'd33;
  localparam logic [5:0] OP_JE        = 6'd34;
  localparam logic [5:0] OP_JNE       = 6'd35;
  localparam logic [5:0] OP_JNEG      = 6'd36;
  localparam logic [5:0] OP_JMP       = 6'd37;
  localparam logic [5:0] OP_LABEL     = 6'd38;
  localparam logic [5:0] OP_RET       = 6'd39;
  localparam logic [5:0] OP_PUSH      = 6'd40;
  localparam logic [5:0] OP_POP       = 6'd41;
  localparam logic [5:0] OP_INC_STACK = 6'd42;
  localparam logic [5:0] OP_DEC_STACK = 6'd43;
  localparam logic [5:0] OP_RESTART   = 6'd44;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_LABEL_FULL = 2'd1;
  localparam logic [1:0] ERR_PEND_FULL  = 2'd2;

  typedef struct packed {
    logic [5:0]         op;
    logic [2:0]         first_reg;
    logic [2:0]         second_reg;
    logic signed [31:0] immediate;
    logic [4:0]         label_id;
  } cmd_t;

  typedef struct packed {
    logic [15:0] write_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic [1:0]  error_code;
    logic        last;
  } wr_t;

  typedef enum logic [1:0] {K_EMIT, K_BRANCH, K_LABEL, K_RESTART} kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [BUF_BYTES*8-1:0] bytes;
    logic [LEN_W-1:0]       len;
    logic [4:0]             label_id;
  } job_t;

  function automatic logic [2:0] reg_code(input logic [2:0] r);
    logic [2:0] c;
    unique case (r)
      3'd0: c = 3'd0;
      3'd1: c = 3'd7;
      3'd2: c = 3'd6;
      3'd3: c = 3'd2;
      3'd4: c = 3'd1;
      3'd5: c = 3'd3;
      3'd6: c = 3'd4;
      3'd7: c = 3'd0;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/xe_chan_if.sv @@
// xe_chan_if: valid/ready channel with a typed payload
// no dependencies
interface xe_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/xe_ram.sv @@
// xe_ram: generic single write port, single read port ram with registered read
// no dependencies
module xe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ sv/xe_front.sv @@
// xe_front: accepts operations, holds the helper address and builds the byte image of each item
// depends on xe_pkg and xe_chan_if
module xe_front import xe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  xe_chan_if.sink    cmd,
  xe_chan_if.sink    cfg,
  output logic       push,
  output job_t       job,
  input  logic       full
);
  logic [31:0] helper;

  always_ff @(posedge clk) begin
    if (rst) begin
      helper <= '0;
    end else if (cfg.valid) begin
      helper <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  function automatic void put_b(inout logic [BUF_BYTES*8-1:0] bf, inout logic [LEN_W-1:0] n,
                                input logic [7:0] v);
    bf[8*n +: 8] = v;
    n = n + 5'd1;
  endfunction

  function automatic void put_w(inout logic [BUF_BYTES*8-1:0] bf, inout logic [LEN_W-1:0] n,
                                input logic [31:0] v);
    put_b(bf, n, v[7:0]);
    put_b(bf, n, v[15:8]);
    put_b(bf, n, v[23:16]);
    put_b(bf, n, v[31:24]);
  endfunction

  function automatic void mov_rr(inout logic [BUF_BYTES*8-1:0] bf, inout logic [LEN_W-1:0] n,
                                 input logic [2:0] d, input logic [2:0] s);
    if (d != s) begin
      put_b(bf, n, 8'h89);
      put_b(bf, n, {2'b11, reg_code(s), reg_code(d)});
    end
  endfunction

  function automatic void imm_op(inout logic [BUF_BYTES*8-1:0] bf, inout logic [LEN_W-1:0] n,
                                 input logic [2:0] d, input logic [7:0] short_op,
                                 input logic [4:0] mr, input logic [31:0] v);
    if (d == 3'd0) begin
      put_b(bf, n, short_op);
    end else begin
      put_b(bf, n, 8'h81);
      put_b(bf, n, {mr, reg_code(d)});
    end
    put_w(bf, n, v);
  endfunction

  function automatic void call_seq(inout logic [BUF_BYTES*8-1:0] bf, inout logic [LEN_W-1:0] n,
                                   input logic [31:0] addr, input logic [1:0] nargs);
    put_b(bf, n, 8'hb8);
    put_w(bf, n, addr);
    if (nargs >= 2'd3) begin
      put_b(bf, n, 8'h52);
    end
    if (nargs >= 2'd2) begin
      put_b(bf, n, 8'h56);
    end
    put_b(bf, n, 8'h57);
    put_b(bf, n, 8'hff);
    put_b(bf, n, 8'hd0);
    put_b(bf, n, 8'h83);
    put_b(bf, n, 8'hc4);
    put_b(bf, n, {4'd0, nargs, 2'b00});
  endfunction

  always_comb begin
    logic [BUF_BYTES*8-1:0] bf;
    logic [LEN_W-1:0]       n;
    logic [2:0]             a;
    logic [2:0]             b;
    logic [31:0]            imm;
    kind_t                  kind;
    bf   = '0;
    n    = '0;
    a    = cmd.data.first_reg;
    b    = cmd.data.second_reg;
    imm  = cmd.data.immediate;
    kind = K_EMIT;
    unique case (cmd.data.op)
      OP_MOVI: begin
        put_b(bf, n, {5'b10111, reg_code(a)});
        put_w(bf, n, imm);
      end
      OP_MOVR: mov_rr(bf, n, a, b);
      OP_CMOVS, OP_CMOVNE, OP_CMOVE: begin
        put_b(bf, n, 8'h0f);
        put_b(bf, n, (cmd.data.op == OP_CMOVS) ? 8'h48 :
                     ((cmd.data.op == OP_CMOVNE) ? 8'h45 : 8'h44));
        put_b(bf, n, {2'b11, reg_code(a), reg_code(b)});
      end
      OP_ADD, OP_AND, OP_OR, OP_XOR, OP_SUB: begin
        unique case (cmd.data.op)
          OP_ADD:  put_b(bf, n, 8'h01);
          OP_AND:  put_b(bf, n, 8'h21);
          OP_OR:   put_b(bf, n, 8'h09);
          OP_XOR:  put_b(bf, n, 8'h31);
          default: put_b(bf, n, 8'h29);
        endcase
        put_b(bf, n, {2'b11, reg_code(b), reg_code(a)});
      end
      OP_ADDI:      imm_op(bf, n, a, 8'h05, 5'b11000, imm);
      OP_SUBI:      imm_op(bf, n, a, 8'h2d, 5'b11101, imm);
      OP_ANDI:      imm_op(bf, n, a, 8'h25, 5'b11100, imm);
      OP_CMPI:      imm_op(bf, n, a, 8'h3d, 5'b11111, imm);
      OP_INC_STACK: imm_op(bf, n, 3'd6, 8'h05, 5'b11000, imm);
      OP_DEC_STACK: imm_op(bf, n, 3'd6, 8'h2d, 5'b11101, imm);
      OP_NOT: begin
        put_b(bf, n, 8'hf7);
        put_b(bf, n, {5'b11010, reg_code(a)});
      end
      OP_SHR, OP_SHL: begin
        mov_rr(bf, n, 3'd3, 3'd4);
        mov_rr(bf, n, 3'd4, b);
        put_b(bf, n, 8'hd3);
        put_b(bf, n, {(cmd.data.op == OP_SHR) ? 5'b11101 : 5'b11100, reg_code(a)});
        mov_rr(bf, n, 3'd4, 3'd3);
      end
      OP_MUL: begin
        put_b(bf, n, 8'h0f);
        put_b(bf, n, 8'haf);
        put_b(bf, n, {2'b11, reg_code(a), reg_code(b)});
      end
      OP_DIV: begin
        mov_rr(bf, n, 3'd0, a);
        put_b(bf, n, 8'h99);
        put_b(bf, n, 8'hf7);
        put_b(bf, n, {5'b11111, reg_code(b)});
        mov_rr(bf, n, a, 3'd0);
      end
      OP_MOD: begin
        mov_rr(bf, n, 3'd1, a);
        mov_rr(bf, n, 3'd2, b);
        call_seq(bf, n, helper, 2'd2);
        mov_rr(bf, n, a, 3'd0);
      end
      OP_LDR: begin
        put_b(bf, n, 8'h8b);
        put_b(bf, n, {2'b00, reg_code(a), reg_code(a)});
      end
      OP_LDR_STACK, OP_STR_STACK: begin
        put_b(bf, n, (cmd.data.op == OP_LDR_STACK) ? 8'h8b : 8'h89);
        put_b(bf, n, {2'b01, reg_code(a), 3'b100});
        put_b(bf, n, 8'h24);
        put_b(bf, n, imm[7:0]);
      end
      OP_LDRB: begin
        put_b(bf, n, 8'h8a);
        put_b(bf, n, {5'b00010, reg_code(a)});
        imm_op(bf, n, 3'd3, 8'h25, 5'b11100, 32'h0000_00ff);
        mov_rr(bf, n, a, 3'd3);
      end
      OP_LDRS: begin
        put_b(bf, n, 8'h66);
        put_b(bf, n, 8'h8b);
        put_b(bf, n, {5'b00010, reg_code(a)});
        imm_op(bf, n, 3'd3, 8'h25, 5'b11100, 32'h0000_ffff);
        mov_rr(bf, n, a, 3'd3);
      end
      OP_LDRW, OP_STRB, OP_STRW: begin
        unique case (cmd.data.op)
          OP_LDRW: put_b(bf, n, 8'h8b);
          OP_STRB: put_b(bf, n, 8'h88);
          default: put_b(bf, n, 8'h89);
        endcase
        put_b(bf, n, {5'b00010, reg_code(a)});
      end
      OP_STRS: begin
        put_b(bf, n, 8'h66);
        put_b(bf, n, 8'h89);
        put_b(bf, n, {5'b00010, reg_code(a)});
      end
      OP_CALL:  call_seq(bf, n, imm, 2'd1);
      OP_CALL2: call_seq(bf, n, imm, 2'd2);
      OP_CALL3: call_seq(bf, n, imm, 2'd3);
      OP_CALLR: begin
        put_b(bf, n, 8'hff);
        put_b(bf, n, {5'b11010, reg_code(a)});
      end
      OP_CMPR: begin
        put_b(bf, n, 8'h39);
        put_b(bf, n, {2'b11, reg_code(a), reg_code(b)});
      end
      OP_JE, OP_JNE, OP_JNEG: begin
        kind = K_BRANCH;
        put_b(bf, n, 8'h0f);
        put_b(bf, n, (cmd.data.op == OP_JE) ? 8'h84 :
                     ((cmd.data.op == OP_JNE) ? 8'h85 : 8'h88));
        put_w(bf, n, 32'd0);
      end
      OP_JMP: begin
        kind = K_BRANCH;
        put_b(bf, n, 8'he9);
        put_w(bf, n, 32'd0);
      end
      OP_LABEL:   kind = K_LABEL;
      OP_RESTART: kind = K_RESTART;
      OP_RET:     put_b(bf, n, 8'hc3);
      OP_PUSH: begin
        for (int i = 0; i < 8; i++) begin
          if (3'(i) >= a && 3'(i) <= b) begin
            put_b(bf, n, {5'b01010, reg_code(3'(i))});
          end
        end
      end
      OP_POP: begin
        for (int i = 7; i >= 0; i--) begin
          if (3'(i) >= a && 3'(i) <= b) begin
            put_b(bf, n, {5'b01011, reg_code(3'(i))});
          end
        end
      end
      default: ;
    endcase
    job.kind     = kind;
    job.bytes    = bf;
    job.len      = n;
    job.label_id = cmd.data.label_id;
  end
endmodule

@@ sv/xe_queue.sv @@
// xe_queue: two-entry queue of decoded items between front and back
// depends on xe_pkg
module xe_queue import xe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic nonempty
);
  job_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign pop_job  = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= push_job;
    end
  end
endmodule

@@ sv/xe_back.sv @@
// xe_back: emits code words, resolves branches, keeps label and pending patch tables
// depends on xe_pkg, xe_chan_if and xe_ram
module xe_back import xe_pkg::*; #(
  parameter int LABEL_SLOTS    = LABEL_SLOTS_DEF,
  parameter int CODE_ADDR_BITS = CODE_ADDR_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  job_t     qjob,
  input  logic     qvalid,
  output logic     qpop,
  xe_chan_if.source wr
);
  localparam int PW  = $clog2(LABEL_SLOTS);
  localparam int CW  = $clog2(LABEL_SLOTS + 1);
  localparam int NW  = $clog2(MAX_RESULTS + 1);
  localparam int CAB = CODE_ADDR_BITS;
  localparam int EW  = 5 + CAB;

  typedef enum logic [2:0] {
    S_IDLE, S_BRANCH, S_WORDS, S_STATUS, S_RD, S_CHK, S_END
  } state_t;

  state_t                 state;
  job_t                   j;
  logic [1:0]             err;
  logic [2:0]             k;
  logic [CAB-1:0]         pos;
  logic [CAB-1:0]         lpos [NUM_LABELS];
  logic [NUM_LABELS-1:0]  lvalid;
  logic [CW-1:0]          lcount;
  logic [LABEL_SLOTS-1:0] pvalid;
  logic [CW-1:0]          pcount;
  logic [CW-1:0]          scan;
  logic [NW-1:0]          pn;
  logic                   held_valid;
  logic [CAB-1:0]         held_addr;
  logic [31:0]            held_data;
  logic [15:0]            st_addr;
  logic [1:0]             st_err;
  logic                   out_valid;
  wr_t                    out;

  logic                   out_free;
  logic                   load;
  logic [LEN_W-1:0]       plen;
  logic [CAB-1:0]         dpos;
  logic                   lab_hit;
  logic [31:0]            disp;
  logic [5:0]             base;
  logic [5:0]             rem;
  logic                   last_w;
  logic                   pend_room;
  logic                   we;
  logic                   re;
  logic [EW-1:0]          rdata;
  logic [4:0]             rid;
  logic [CAB-1:0]         rpos;
  logic                   match;
  logic [31:0]            patch;

  assign out_free  = !out_valid || wr.ready;
  assign load      = out_free && ((state == S_WORDS) || (state == S_STATUS) ||
                                  (state == S_END) ||
                                  ((state == S_CHK) && match && held_valid));
  assign plen      = j.len - 5'd4;
  assign dpos      = pos + CAB'(plen);
  assign lab_hit   = lvalid[j.label_id];
  assign disp      = 32'(lpos[j.label_id]) - (32'(dpos) + 32'd4);
  assign base      = {1'b0, k, 2'b00};
  assign rem       = {1'b0, j.len} - base;
  assign last_w    = (rem <= 6'd4);
  assign pend_room = (pcount < CW'(LABEL_SLOTS));
  assign we        = (state == S_BRANCH) && !lab_hit && pend_room;
  assign re        = (state == S_RD);
  assign rid       = rdata[EW-1 -: 5];
  assign rpos      = rdata[CAB-1:0];
  assign match     = pvalid[scan[PW-1:0]] && (rid == j.label_id);
  assign patch     = 32'(pos) - 32'(rpos) - 32'd4;
  assign qpop      = (state == S_IDLE) && qvalid;
  assign wr.valid  = out_valid;
  assign wr.data   = out;

  xe_ram #(.WIDTH(EW), .DEPTH(LABEL_SLOTS)) u_pend (
    .clk   (clk),
    .we    (we),
    .waddr (pcount[PW-1:0]),
    .wdata ({j.label_id, dpos}),
    .re    (re),
    .raddr (scan[PW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      lvalid    <= '0;
      lcount    <= '0;
      pvalid    <= '0;
      pcount    <= '0;
    end else begin
      out_valid <= load || (out_valid && !wr.ready);
      unique case (state)
        S_IDLE: begin
          if (qvalid) begin
            j   <= qjob;
            err <= ERR_OK;
            k   <= '0;
            unique case (qjob.kind)
              K_EMIT:   state <= S_WORDS;
              K_BRANCH: state <= S_BRANCH;
              K_LABEL: begin
                if (lcount >= CW'(LABEL_SLOTS)) begin
                  st_addr <= 16'(pos);
                  st_err  <= ERR_LABEL_FULL;
                  state   <= S_STATUS;
                end else begin
                  if (!lvalid[qjob.label_id]) begin
                    lvalid[qjob.label_id] <= 1'b1;
                    lpos[qjob.label_id]   <= pos;
                  end
                  lcount     <= lcount + CW'(1);
                  scan       <= '0;
                  pn         <= '0;
                  held_valid <= 1'b0;
                  state      <= S_RD;
                end
              end
              default: begin
                pos     <= '0;
                lvalid  <= '0;
                lcount  <= '0;
                pvalid  <= '0;
                pcount  <= '0;
                st_addr <= '0;
                st_err  <= ERR_OK;
                state   <= S_STATUS;
              end
            endcase
          end
        end
        S_BRANCH: begin
          if (lab_hit) begin
            j.bytes[8*plen +: 32] <= disp;
          end else if (pend_room) begin
            pvalid[pcount[PW-1:0]] <= 1'b1;
            pcount                 <= pcount + CW'(1);
          end else begin
            err <= ERR_PEND_FULL;
          end
          state <= S_WORDS;
        end
        S_WORDS: begin
          if (out_free) begin
            out       <= '{write_address: 16'(pos + CAB'(base)),
                           write_data: j.bytes[32*k +: 32],
                           byte_count: last_w ? rem[2:0] : 3'd4,
                           error_code: err,
                           last: last_w};
            k         <= k + 3'd1;
            if (last_w) begin
              pos   <= pos + CAB'(j.len);
              state <= S_IDLE;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out       <= '{write_address: st_addr, write_data: '0, byte_count: '0,
                           error_code: st_err, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_RD: begin
          if (scan < pcount && pn < NW'(MAX_RESULTS)) begin
            state <= S_CHK;
          end else begin
            state <= S_END;
          end
        end
        S_CHK: begin
          if (match) begin
            if (!held_valid || out_free) begin
              if (held_valid) begin
                out       <= '{write_address: 16'(held_addr), write_data: held_data,
                               byte_count: 3'd4, error_code: ERR_OK, last: 1'b0};
              end
              held_valid             <= 1'b1;
              held_addr              <= rpos;
              held_data              <= patch;
              pn                     <= pn + NW'(1);
              pvalid[scan[PW-1:0]]   <= 1'b0;
              scan                   <= scan + CW'(1);
              state                  <= S_RD;
            end
          end else begin
            scan  <= scan + CW'(1);
            state <= S_RD;
          end
        end
        default: begin
          if (out_free) begin
            if (held_valid) begin
              out <= '{write_address: 16'(held_addr), write_data: held_data,
                       byte_count: 3'd4, error_code: ERR_OK, last: 1'b1};
            end else begin
              out <= '{write_address: 16'(pos), write_data: '0, byte_count: '0,
                       error_code: ERR_OK, last: 1'b1};
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

@@ sv/x86_instruction_emitter.sv @@
// x86_instruction_emitter: top level, front decode, item queue and emit back end
// depends on xe_pkg, xe_chan_if, xe_front, xe_queue and xe_back
//
// cmd carries one abstract operation per item; wr returns code writes of up to four
// bytes at the running code position, the final write of an operation flagged by last.
// cfg writes the helper call address used by the modulo operation; it is always ready.
// The front decodes an item into its byte image in the cycle it is accepted and places
// it in a two-entry queue, so cmd keeps accepting while the back end works or wr stalls.
// The back end picks up an item in its idle state, passes a branch through a resolve state,
// then gives one write per cycle while wr does not stall.
// A label definition walks the pending patch memory, a read state then a check state per
// slot; status-only results (restart, full label table) are a single write.
// The wr output register holds a write until taken; while wr stalls the back end stops
// and the queue fills, then cmd drops ready.
// Reset clears the code position, label and pending valid bits, counts and helper address.
module x86_instruction_emitter import xe_pkg::*; #(
  parameter int LABEL_SLOTS    = LABEL_SLOTS_DEF,
  parameter int CODE_ADDR_BITS = CODE_ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  xe_chan_if.sink   cmd,
  xe_chan_if.sink   cfg,
  xe_chan_if.source wr
);
  logic push;
  logic full;
  logic pop;
  logic nonempty;
  job_t fjob;
  job_t qjob;

  xe_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .cfg  (cfg),
    .push (push),
    .job  (fjob),
    .full (full)
  );

  xe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (fjob),
    .full     (full),
    .pop      (pop),
    .pop_job  (qjob),
    .nonempty (nonempty)
  );

  xe_back #(
    .LABEL_SLOTS    (LABEL_SLOTS),
    .CODE_ADDR_BITS (CODE_ADDR_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qjob   (qjob),
    .qvalid (nonempty),
    .qpop   (pop),
    .wr     (wr)
  );
endmodule
